@@ design/cbs_pkg.sv @@
package cbs_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int ID_W      = 16;
    localparam int TIME_W    = 48;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int DATA_W    = 64;
    localparam int PADDR_W   = 4;

    localparam logic [TIME_W-1:0] LIMIT_RST = TIME_W'(1000000);

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    // One parked context as kept in the table memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] evict;
        logic [TIME_W-1:0] idle;
    } t_entry;

    // Control from the sequencer to the table memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic stamp;
    } t_mem_ctl;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

@@ design/cbs_ctx_mem.sv @@
module cbs_ctx_mem #(
    parameter int DEPTH = cbs_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  cbs_pkg::t_mem_ctl             i_ctl,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [cbs_pkg::ID_W-1:0]      i_id,
    input  logic [cbs_pkg::TIME_W-1:0]    i_now,
    input  logic [cbs_pkg::TIME_W-1:0]    i_dt,
    output cbs_pkg::t_entry               o_rdata
);

    cbs_pkg::t_entry r_mem [DEPTH];
    cbs_pkg::t_entry r_rdata;
    cbs_pkg::t_entry n_wdata;

    // A write always follows the read of the same entry in the cycle before it,
    // so the aged value is built from the registered read data.
    always_comb begin
        if (i_ctl.stamp) begin
            n_wdata.id    = i_id;
            n_wdata.evict = i_now;
            n_wdata.idle  = '0;
        end else begin
            n_wdata.id    = r_rdata.id;
            n_wdata.evict = r_rdata.evict;
            n_wdata.idle  = cbs_pkg::sat_add(r_rdata.idle, i_dt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= n_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/context_buffer_scheduler.sv @@
// Channel   Signals                                   Direction  Handshake
// request   i_cmd, i_ctx_id, i_now                    in         start & !busy
// result    o_slot, o_chosen_id, o_status,
//           o_starving, o_can_map                     out        o_valid, one cycle
// config    psel, penable, pwrite, paddr, pwdata,
//           prdata, pready                            in/out     APB, pready tied high
//
// A select, a remove or an add sweeps the table memory once at one entry per
// cycle over its A allocated entries, where A is the number of allocated table
// entries. An add that is not refused as full then sweeps it a second time for
// the read-modify-write that ages the other entries and stamps the target
// entry. An unknown command skips the sweep.
// Reset (synchronous, active low) clears valid bits and counters; the memory
// needs no clearing pass. The receiver cannot stall: each result is shown
// for exactly one cycle, as busy falls or, for an unknown command, while idle.
module context_buffer_scheduler #(
    parameter int DEPTH = cbs_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [cbs_pkg::CMD_W-1:0]        i_cmd,
    input  logic [cbs_pkg::ID_W-1:0]         i_ctx_id,
    input  logic [cbs_pkg::TIME_W-1:0]       i_now,
    output logic                             o_valid,
    output logic [$clog2(DEPTH)-1:0]         o_slot,
    output logic [cbs_pkg::ID_W-1:0]         o_chosen_id,
    output logic [cbs_pkg::STAT_W-1:0]       o_status,
    output logic                             o_starving,
    output logic                             o_can_map,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cbs_pkg::PADDR_W-1:0]      paddr,
    input  logic [cbs_pkg::DATA_W-1:0]       pwdata,
    output logic [cbs_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_AGE
    } t_state;

    t_state                        r_state;
    logic [cbs_pkg::CMD_W-1:0]     r_cmd;
    logic [cbs_pkg::ID_W-1:0]      r_id;
    logic [cbs_pkg::TIME_W-1:0]    r_now;
    logic [cbs_pkg::TIME_W-1:0]    r_limit;
    logic [DEPTH-1:0]              r_valid;
    logic [CNT_W-1:0]              r_alloc;
    logic [IDX_W-1:0]              r_cur;
    logic [cbs_pkg::TIME_W-1:0]    r_last;
    logic [cbs_pkg::TIME_W-1:0]    r_dt;
    logic [IDX_W-1:0]              r_target;

    // Sweep bookkeeping: reads are issued in order and land in the next cycle.
    logic [IDX_W-1:0]              r_rd_idx;
    logic [CNT_W-1:0]              r_issued;
    logic                          r_pend;
    logic [IDX_W-1:0]              r_pend_idx;

    // Search results gathered during a sweep.
    logic                          r_hit;
    logic [IDX_W-1:0]              r_hit_idx;
    logic                          r_free;
    logic [IDX_W-1:0]              r_free_idx;
    logic                          r_starv;
    logic [IDX_W-1:0]              r_starv_idx;
    logic [cbs_pkg::ID_W-1:0]      r_starv_id;
    logic                          r_best;
    logic [IDX_W-1:0]              r_best_idx;
    logic [cbs_pkg::TIME_W-1:0]    r_best_evict;
    logic [cbs_pkg::ID_W-1:0]      r_best_id;
    logic [cbs_pkg::ID_W-1:0]      r_cur_id;

    logic                          r_o_valid;
    logic [IDX_W-1:0]              r_o_slot;
    logic [cbs_pkg::ID_W-1:0]      r_o_chosen_id;
    logic [cbs_pkg::STAT_W-1:0]    r_o_status;
    logic                          r_o_starving;
    logic                          r_o_can_map;

    logic                          n_issue;
    logic                          n_sweep_end;
    logic [IDX_W-1:0]              n_rd_idx;
    logic [IDX_W-1:0]              n_sel_start;
    logic                          n_cfg_wr;
    cbs_pkg::t_mem_ctl             n_mem_ctl;
    cbs_pkg::t_entry               w_rdata;

    // The next index wraps at the number of allocated entries, which gives the
    // select sweep its order starting just after the current slot.
    always_comb begin
        n_issue     = (r_state != S_IDLE) && (r_issued != r_alloc);
        n_sweep_end = (r_state != S_IDLE) && !n_issue && !r_pend;
        n_rd_idx    = (CNT_W'(r_rd_idx) + CNT_W'(1) == r_alloc) ? '0 : r_rd_idx + IDX_W'(1);
        n_sel_start = (CNT_W'(r_cur) + CNT_W'(1) == r_alloc) ? '0 : r_cur + IDX_W'(1);
        n_cfg_wr    = psel && penable && pwrite && !paddr[3];
        n_mem_ctl.rd_en = n_issue;
        n_mem_ctl.wr_en = (r_state == S_AGE) && r_pend;
        n_mem_ctl.stamp = (r_pend_idx == r_target);
    end

    cbs_ctx_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (n_mem_ctl),
        .i_rd_addr (r_rd_idx),
        .i_wr_addr (r_pend_idx),
        .i_id      (r_id),
        .i_now     (r_now),
        .i_dt      (r_dt),
        .o_rdata   (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= cbs_pkg::LIMIT_RST;
            r_valid     <= '0;
            r_alloc     <= '0;
            r_cur       <= '0;
            r_last      <= '0;
            r_issued    <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_starv     <= 1'b0;
            r_best      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;

            if (n_cfg_wr) begin
                r_limit <= pwdata[cbs_pkg::TIME_W-1:0];
            end

            if (n_issue) begin
                r_rd_idx <= n_rd_idx;
                r_issued <= r_issued + CNT_W'(1);
            end
            r_pend     <= n_issue;
            r_pend_idx <= r_rd_idx;

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd    <= i_cmd;
                        r_id     <= i_ctx_id;
                        r_now    <= i_now;
                        r_issued <= '0;
                        r_pend   <= 1'b0;
                        r_hit    <= 1'b0;
                        r_free   <= 1'b0;
                        r_starv  <= 1'b0;
                        r_best   <= 1'b0;
                        r_rd_idx <= (i_cmd == cbs_pkg::CMD_SELECT) ? n_sel_start : '0;
                        if (i_cmd == cbs_pkg::CMD_ADD || i_cmd == cbs_pkg::CMD_SELECT ||
                            i_cmd == cbs_pkg::CMD_REMOVE) begin
                            r_state <= S_SCAN;
                        end else begin
                            // An unknown command changes nothing.
                            r_o_valid     <= 1'b1;
                            r_o_slot      <= '0;
                            r_o_chosen_id <= '0;
                            r_o_status    <= cbs_pkg::ST_OK;
                            r_o_starving  <= 1'b0;
                            r_o_can_map   <= ~&r_valid;
                        end
                    end
                end

                S_SCAN: begin
                    if (r_pend) begin
                        if (r_cmd == cbs_pkg::CMD_SELECT) begin
                            // The lowest starving entry wins over everything.
                            if (r_valid[r_pend_idx] && w_rdata.idle >= r_limit &&
                                (!r_starv || r_pend_idx < r_starv_idx)) begin
                                r_starv     <= 1'b1;
                                r_starv_idx <= r_pend_idx;
                                r_starv_id  <= w_rdata.id;
                            end
                            // Strictly greater eviction time, so ties go to the
                            // entry met first in sweep order.
                            if (r_pend_idx != r_cur && r_valid[r_pend_idx] &&
                                (!r_best || w_rdata.evict > r_best_evict)) begin
                                r_best       <= 1'b1;
                                r_best_idx   <= r_pend_idx;
                                r_best_evict <= w_rdata.evict;
                                r_best_id    <= w_rdata.id;
                            end
                            if (r_pend_idx == r_cur) begin
                                r_cur_id <= w_rdata.id;
                            end
                        end else begin
                            if (!r_hit && w_rdata.id == r_id) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_pend_idx;
                            end
                            if (!r_free && !r_valid[r_pend_idx]) begin
                                r_free     <= 1'b1;
                                r_free_idx <= r_pend_idx;
                            end
                        end
                    end

                    if (n_sweep_end) begin
                        r_o_chosen_id <= '0;
                        r_o_starving  <= 1'b0;
                        r_o_slot      <= '0;
                        r_o_status    <= cbs_pkg::ST_OK;
                        r_o_can_map   <= ~&r_valid;
                        r_state       <= S_IDLE;
                        r_o_valid     <= 1'b1;

                        priority case (r_cmd)
                            cbs_pkg::CMD_SELECT: begin
                                if (r_starv || r_best || r_valid[r_cur]) begin
                                    r_o_can_map <= 1'b1;
                                    priority if (r_starv) begin
                                        r_o_starving          <= 1'b1;
                                        r_o_slot              <= r_starv_idx;
                                        r_o_chosen_id         <= r_starv_id;
                                        r_cur                 <= r_starv_idx;
                                        r_valid[r_starv_idx]  <= 1'b0;
                                    end else if (r_best) begin
                                        r_o_slot              <= r_best_idx;
                                        r_o_chosen_id         <= r_best_id;
                                        r_cur                 <= r_best_idx;
                                        r_valid[r_best_idx]   <= 1'b0;
                                    end else begin
                                        // Only the current slot is still parked.
                                        r_o_slot              <= r_cur;
                                        r_o_chosen_id         <= r_cur_id;
                                        r_valid[r_cur]        <= 1'b0;
                                    end
                                end else begin
                                    r_o_status <= cbs_pkg::ST_EMPTY;
                                end
                            end

                            cbs_pkg::CMD_REMOVE: begin
                                if (r_hit) begin
                                    r_o_slot <= r_hit_idx;
                                    if (r_valid[r_hit_idx]) begin
                                        r_valid[r_hit_idx] <= 1'b0;
                                        r_o_can_map        <= 1'b1;
                                    end
                                end else begin
                                    r_o_status <= cbs_pkg::ST_NOT_FOUND;
                                end
                            end

                            default: begin
                                // Add: a matching id wins, then the first free
                                // entry, then a fresh entry at the end.
                                if (!r_hit && !r_free && r_alloc == CNT_W'(DEPTH)) begin
                                    r_o_status <= cbs_pkg::ST_FULL;
                                end else begin
                                    r_o_valid <= 1'b0;
                                    r_state   <= S_AGE;
                                    priority if (r_hit) begin
                                        r_target           <= r_hit_idx;
                                        r_valid[r_hit_idx] <= 1'b1;
                                    end else if (r_free) begin
                                        r_target            <= r_free_idx;
                                        r_valid[r_free_idx] <= 1'b1;
                                    end else begin
                                        r_target                  <= IDX_W'(r_alloc);
                                        r_valid[IDX_W'(r_alloc)]  <= 1'b1;
                                        r_alloc                   <= r_alloc + CNT_W'(1);
                                    end
                                    r_dt     <= (r_now >= r_last) ? r_now - r_last : '0;
                                    r_last   <= r_now;
                                    r_issued <= '0;
                                    r_rd_idx <= '0;
                                    r_pend   <= 1'b0;
                                end
                            end
                        endcase
                    end
                end

                S_AGE: begin
                    // The memory writes each swept entry back in the cycle after
                    // its read: aged, or stamped for the target.
                    if (n_sweep_end) begin
                        r_state       <= S_IDLE;
                        r_o_valid     <= 1'b1;
                        r_o_slot      <= r_target;
                        r_o_chosen_id <= '0;
                        r_o_status    <= cbs_pkg::ST_OK;
                        r_o_starving  <= 1'b0;
                        r_o_can_map   <= ~&r_valid;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_slot      = r_o_slot;
    assign o_chosen_id = r_o_chosen_id;
    assign o_status    = r_o_status;
    assign o_starving  = r_o_starving;
    assign o_can_map   = r_o_can_map;
    assign pready      = 1'b1;
    assign prdata      = paddr[3] ? '0
                                  : {{(cbs_pkg::DATA_W - cbs_pkg::TIME_W){1'b0}}, r_limit};

endmodule
